>>> design/dse_pkg.sv
`timescale 1ns / 1ps
// Package for the dark span extractor: sizes, register indexes, sequencer states
// and the request/response bundles of the mean divider. No dependencies.
package dse_pkg;

    localparam int MAX_RUN      = 256;
    localparam int LINE_LEN_MAX = 4096;

    localparam int PIX_W    = 8;
    localparam int THR_W    = 9;
    localparam int RATIO_W  = 9;
    localparam int LEN_W    = $clog2(MAX_RUN + 1);
    localparam int ADDR_W   = $clog2(MAX_RUN);
    localparam int IDX_W    = $clog2(LINE_LEN_MAX);
    localparam int POS_W    = 12;
    localparam int THICK_W  = 9;
    localparam int MEAN_W   = 16;
    localparam int SUM_W    = PIX_W + ADDR_W;
    localparam int PROD_W   = THR_W + RATIO_W;
    localparam int LEVEL_W  = PROD_W - 8 + 1;
    localparam int DVD_W    = SUM_W + 8;
    localparam int DIV_CNT_W = $clog2(DVD_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_DARK_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_RATIO     = 2'd1;

    localparam logic [THR_W-1:0]   THRESHOLD_RST = 9'd128;
    localparam logic [RATIO_W-1:0] RATIO_RST     = 9'd128;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LEVEL,
        ST_WALK,
        ST_FIN,
        ST_DIV,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [THICK_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [MEAN_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> design/dse_pixel_if.sv
`timescale 1ns / 1ps
// Pixel stream channel: valid/ready plus one pixel and its line-end mark.
// Depends on dse_pkg.
interface dse_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [dse_pkg::PIX_W-1:0] pixel;
    logic                      last_in_line;

    modport source (output valid, output pixel, output last_in_line, input ready);
    modport sink   (input valid, input pixel, input last_in_line, output ready);
endinterface

>>> design/dse_span_if.sv
`timescale 1ns / 1ps
// Span result channel: valid/ready plus position, thickness, mean and overflow flag.
// Depends on dse_pkg.
interface dse_span_if;
    logic                        valid;
    logic                        ready;
    logic [dse_pkg::POS_W-1:0]   span_position;
    logic [dse_pkg::THICK_W-1:0] span_thickness;
    logic [dse_pkg::MEAN_W-1:0]  span_mean_q8;
    logic                        run_overflow;

    modport source (output valid, output span_position, output span_thickness,
                    output span_mean_q8, output run_overflow, input ready);
    modport sink   (input valid, input span_position, input span_thickness,
                    input span_mean_q8, input run_overflow, output ready);
endinterface

>>> design/dse_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: valid/ready plus register index and write data.
// Depends on dse_pkg.
interface dse_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dse_pkg::CFG_IDX_W-1:0]  index;
    logic [dse_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/dse_divider.sv
`timescale 1ns / 1ps
// Restoring radix-2 divider for the span mean, one quotient bit per cycle.
// Depends on dse_pkg (widths and request/response structs).
module dse_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  dse_pkg::div_req_t req,
    output dse_pkg::div_rsp_t rsp
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [dse_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [dse_pkg::THICK_W-1:0]       rem_reg, rem_next;
    logic [dse_pkg::THICK_W-1:0]       dvs_reg, dvs_next;
    logic [dse_pkg::DVD_W-1:0]         dq_reg, dq_next;
    logic [dse_pkg::THICK_W:0]         trial;
    logic [dse_pkg::THICK_W:0]         diff;
    logic                              ge;

    assign trial = {rem_reg, dq_reg[dse_pkg::DVD_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        dq_next   = dq_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = req.divisor;
            dq_next   = req.dividend;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[dse_pkg::THICK_W-1:0] : trial[dse_pkg::THICK_W-1:0];
            dq_next  = {dq_reg[dse_pkg::DVD_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == dse_pkg::DIV_CNT_W'(dse_pkg::DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        dq_reg  <= dq_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg[dse_pkg::MEAN_W-1:0];

endmodule

>>> design/dark_span_extractor_core.sv
`timescale 1ns / 1ps
// Dark span extractor. A pixel that does not close a run is taken while ready stays high.
// A closing pixel starts the span sequencer, which keeps pixel ready low: multiply, level,
// N buffer reads (N = run length, one per cycle through the single read port), trim, the
// divider (24 quotient bits, then done) and a load that waits for a free result register.
// Result register lets the next pixel in while a span transaction waits.
// Async active-low reset: threshold 128, ratio 128, no open run, line index 0.
module dark_span_extractor_core (
    input  logic clk,
    input  logic rst_n,
    dse_pixel_if.sink  pix,
    dse_span_if.source span,
    dse_cfg_if.sink    cfg
);

    // ---------------- configuration registers ----------------
    logic [dse_pkg::THR_W-1:0]   thr_reg;
    logic [dse_pkg::RATIO_W-1:0] ratio_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= dse_pkg::THRESHOLD_RST;
            ratio_reg <= dse_pkg::RATIO_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                dse_pkg::CFG_DARK_THRESHOLD: thr_reg   <= cfg.data[dse_pkg::THR_W-1:0];
                dse_pkg::CFG_EDGE_RATIO:     ratio_reg <= cfg.data[dse_pkg::RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- state ----------------
    dse_pkg::seq_state_t             state_reg, state_next;
    logic [dse_pkg::LEN_W-1:0]       run_len_reg, run_len_next;
    logic [dse_pkg::PIX_W-1:0]       darkest_reg, darkest_next;
    logic [dse_pkg::IDX_W-1:0]       start_reg, start_next;
    logic [dse_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic [dse_pkg::PIX_W-1:0]       term_reg, term_next;
    logic                            has_term_reg, has_term_next;
    logic                            ovf_reg, ovf_next;
    logic [dse_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic [dse_pkg::LEVEL_W-1:0]     level_reg, level_next;
    logic [dse_pkg::ADDR_W-1:0]      walk_idx_reg, walk_idx_next;
    logic                            found_reg, found_next;
    logic [dse_pkg::ADDR_W-1:0]      s_reg, s_next;
    logic [dse_pkg::ADDR_W-1:0]      last_le_reg, last_le_next;
    logic [dse_pkg::SUM_W-1:0]       acc_reg, acc_next;
    logic [dse_pkg::SUM_W-1:0]       sum_le_reg, sum_le_next;
    logic [dse_pkg::THICK_W-1:0]     thick_reg, thick_next;

    // result register
    logic                            out_valid_reg, out_valid_next;
    logic [dse_pkg::POS_W-1:0]       out_pos_reg, out_pos_next;
    logic [dse_pkg::THICK_W-1:0]     out_thick_reg, out_thick_next;
    logic [dse_pkg::MEAN_W-1:0]      out_mean_reg, out_mean_next;
    logic                            out_ovf_reg, out_ovf_next;

    // run buffer: one write port (pixel intake), one registered read port (walk)
    logic [dse_pkg::PIX_W-1:0]       run_buf [dse_pkg::MAX_RUN];
    logic                            buf_we;
    logic [dse_pkg::ADDR_W-1:0]      buf_waddr;
    logic [dse_pkg::ADDR_W-1:0]      buf_raddr;
    logic [dse_pkg::PIX_W-1:0]       rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            run_buf[buf_waddr] <= pix.pixel;
        end
        rd_data_reg <= run_buf[buf_raddr];
    end

    // mean divider
    dse_pkg::div_req_t div_req;
    dse_pkg::div_rsp_t div_rsp;

    dse_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------- datapath helpers ----------------
    logic                          pix_acc;
    logic                          is_dark;
    logic [dse_pkg::LEN_W-1:0]     len_inc;
    logic                          rd_le;          // buffered pixel at or below the level
    logic [dse_pkg::SUM_W-1:0]     acc_add;
    logic                          term_keep;      // bright closing pixel survives the trim
    logic [dse_pkg::THICK_W-1:0]   thick_c;
    logic [dse_pkg::SUM_W-1:0]     sum_c;
    logic                          out_free;

    assign pix.ready  = (state_reg == dse_pkg::ST_IDLE);
    assign pix_acc    = pix.valid && pix.ready;
    assign is_dark    = {1'b0, pix.pixel} < thr_reg;
    assign len_inc    = run_len_reg + 1'b1;
    assign rd_le      = {{(dse_pkg::LEVEL_W - dse_pkg::PIX_W){1'b0}}, rd_data_reg} <= level_reg;
    assign acc_add    = acc_reg + dse_pkg::SUM_W'(rd_data_reg);
    assign term_keep  = has_term_reg &&
                        ({{(dse_pkg::LEVEL_W - dse_pkg::PIX_W){1'b0}}, term_reg} <= level_reg);
    assign out_free   = !out_valid_reg || span.ready;

    // Trimmed span. If the bright closing pixel is kept, the span reaches one past
    // the run; the length fix pulls it back to the run when the start trim is empty.
    // The sum always covers run pixels only.
    always_comb
    begin
        if (term_keep)
        begin
            sum_c = acc_reg;
            if (s_reg == '0)
            begin
                thick_c = dse_pkg::THICK_W'(run_len_reg);
            end
            else
            begin
                thick_c = dse_pkg::THICK_W'(run_len_reg + 1'b1 - dse_pkg::LEN_W'(s_reg));
            end
        end
        else
        begin
            sum_c   = sum_le_reg;
            thick_c = dse_pkg::THICK_W'({1'b0, last_le_reg} + 1'b1 - {1'b0, s_reg});
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        run_len_next   = run_len_reg;
        darkest_next   = darkest_reg;
        start_next     = start_reg;
        idx_next       = idx_reg;
        term_next      = term_reg;
        has_term_next  = has_term_reg;
        ovf_next       = ovf_reg;
        prod_next      = prod_reg;
        level_next     = level_reg;
        walk_idx_next  = walk_idx_reg;
        found_next     = found_reg;
        s_next         = s_reg;
        last_le_next   = last_le_reg;
        acc_next       = acc_reg;
        sum_le_next    = sum_le_reg;
        thick_next     = thick_reg;
        out_valid_next = out_valid_reg && !span.ready;
        out_pos_next   = out_pos_reg;
        out_thick_next = out_thick_reg;
        out_mean_next  = out_mean_reg;
        out_ovf_next   = out_ovf_reg;
        buf_we         = 1'b0;
        buf_waddr      = run_len_reg[dse_pkg::ADDR_W-1:0];
        buf_raddr      = walk_idx_reg + 1'b1;
        div_req.start    = 1'b0;
        div_req.dividend = {sum_c, 8'b0};
        div_req.divisor  = thick_c;

        unique case (state_reg)
            dse_pkg::ST_IDLE:
            begin
                if (pix_acc)
                begin
                    // line index: back to 0 at line end or when the index space runs out
                    if (pix.last_in_line ||
                        idx_reg == dse_pkg::IDX_W'(dse_pkg::LINE_LEN_MAX - 1))
                    begin
                        idx_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end

                    if (is_dark)
                    begin
                        if (run_len_reg == '0)
                        begin
                            start_next   = idx_reg;
                            darkest_next = pix.pixel;
                        end
                        else if (pix.pixel < darkest_reg)
                        begin
                            darkest_next = pix.pixel;
                        end
                        if (run_len_reg < dse_pkg::LEN_W'(dse_pkg::MAX_RUN))
                        begin
                            buf_we       = 1'b1;
                            run_len_next = len_inc;
                        end
                        has_term_next = 1'b0;
                        // line end wins over a full buffer
                        if (pix.last_in_line)
                        begin
                            ovf_next   = 1'b0;
                            state_next = dse_pkg::ST_MUL;
                        end
                        else if (len_inc >= dse_pkg::LEN_W'(dse_pkg::MAX_RUN))
                        begin
                            ovf_next   = 1'b1;
                            state_next = dse_pkg::ST_MUL;
                        end
                    end
                    else if (run_len_reg != '0)
                    begin
                        term_next     = pix.pixel;
                        has_term_next = 1'b1;
                        ovf_next      = 1'b0;
                        state_next    = dse_pkg::ST_MUL;
                    end
                end
            end

            dse_pkg::ST_MUL:
            begin
                // darkest is below the threshold, so the difference is non-negative
                prod_next  = dse_pkg::PROD_W'(thr_reg - dse_pkg::THR_W'(darkest_reg)) *
                             dse_pkg::PROD_W'(ratio_reg);
                state_next = dse_pkg::ST_LEVEL;
            end

            dse_pkg::ST_LEVEL:
            begin
                level_next    = dse_pkg::LEVEL_W'(darkest_reg) +
                                dse_pkg::LEVEL_W'(prod_reg[dse_pkg::PROD_W-1:8]);
                buf_raddr     = '0;
                walk_idx_next = '0;
                found_next    = 1'b0;
                s_next        = '0;
                last_le_next  = '0;
                acc_next      = '0;
                sum_le_next   = '0;
                state_next    = dse_pkg::ST_WALK;
            end

            dse_pkg::ST_WALK:
            begin
                // one buffered pixel per cycle: first and last at-or-below-level
                // positions, running sum from the first one on
                if (found_reg || rd_le)
                begin
                    acc_next = acc_add;
                end
                if (rd_le)
                begin
                    if (!found_reg)
                    begin
                        s_next = walk_idx_reg;
                    end
                    found_next   = 1'b1;
                    last_le_next = walk_idx_reg;
                    sum_le_next  = acc_add;
                end
                walk_idx_next = walk_idx_reg + 1'b1;
                if ({1'b0, walk_idx_reg} == run_len_reg - 1'b1)
                begin
                    state_next = dse_pkg::ST_FIN;
                end
            end

            dse_pkg::ST_FIN:
            begin
                thick_next    = thick_c;
                div_req.start = 1'b1;
                state_next    = dse_pkg::ST_DIV;
            end

            dse_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = dse_pkg::ST_DONE;
                end
            end

            dse_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = dse_pkg::POS_W'(start_reg) + dse_pkg::POS_W'(s_reg) +
                                     dse_pkg::POS_W'(thick_reg >> 1);
                    out_thick_next = thick_reg;
                    out_mean_next  = div_rsp.quotient;
                    out_ovf_next   = ovf_reg;
                    run_len_next   = '0;
                    state_next     = dse_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dse_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dse_pkg::ST_IDLE;
            run_len_reg   <= '0;
            darkest_reg   <= '0;
            start_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_len_reg   <= run_len_next;
            darkest_reg   <= darkest_next;
            start_reg     <= start_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg      <= term_next;
        has_term_reg  <= has_term_next;
        ovf_reg       <= ovf_next;
        prod_reg      <= prod_next;
        level_reg     <= level_next;
        walk_idx_reg  <= walk_idx_next;
        found_reg     <= found_next;
        s_reg         <= s_next;
        last_le_reg   <= last_le_next;
        acc_reg       <= acc_next;
        sum_le_reg    <= sum_le_next;
        thick_reg     <= thick_next;
        out_pos_reg   <= out_pos_next;
        out_thick_reg <= out_thick_next;
        out_mean_reg  <= out_mean_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // ---------------- result channel ----------------
    assign span.valid          = out_valid_reg;
    assign span.span_position  = out_pos_reg;
    assign span.span_thickness = out_thick_reg;
    assign span.span_mean_q8   = out_mean_reg;
    assign span.run_overflow   = out_ovf_reg;

endmodule
